/* src/annexb_start_code_splitter_top_macros.svh */
// ============================================================================
// Assertion macros for the start code splitter
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ============================================================================
`ifndef ANNEXB_START_CODE_SPLITTER_TOP_MACROS_SVH
`define ANNEXB_START_CODE_SPLITTER_TOP_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked at every rising clock edge out of reset.
`define ACS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("start code splitter check failed");
// Next-cycle implication.
`define ACS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("start code splitter check failed");
`else
`define ACS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define ACS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* src/acsplit_pkg.sv */
// ============================================================================
// acsplit_pkg
// Shared types and constants of the Annex B start code splitter.
// ============================================================================
package acsplit_pkg;

   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 32;
   localparam int TYPE_W   = 5;
   localparam int INDEX_W  = 32;
   localparam int ZRUN_W   = 3;
   localparam int RELCNT_W = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   // Command queue between the classifier and the result expander.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_UNITS    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INSERT_DELIM = 1'd1;

   // Stream byte codes.
   localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
   localparam logic [BYTE_W-1:0] BYTE_ONE  = 8'h01;
   localparam logic [BYTE_W-1:0] TYPE_MASK = 8'h1F;

   // Unit type of an access unit delimiter.
   localparam logic [TYPE_W-1:0] AUD_TYPE = 5'd9;

   // Zero run states: up to three zeros held, or a released long run.
   localparam logic [ZRUN_W-1:0] ZRUN_HELD_MAX = 3'd3;
   localparam logic [ZRUN_W-1:0] ZRUN_RELEASED = 3'd4;

   localparam logic [LEN_W-1:0]   LEN_MAX   = '1;
   localparam logic [INDEX_W-1:0] INDEX_MAX = '1;

   // Result kinds.
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_RECORD = 1'b1;

   // One command: a number of held zeros to release, then a tail that is
   // either a data byte or an end-of-unit record.
   typedef struct packed {
      logic [RELCNT_W-1:0] rel_cnt;
      logic                is_record;
      logic [BYTE_W-1:0]   data_byte;
      logic                first_unit;
      logic [INDEX_W-1:0]  unit_index;
   } cmd_type;

   // Classifier state, exported for checks.
   typedef struct packed {
      logic [ZRUN_W-1:0]  zero_run;
      logic [INDEX_W-1:0] units_done;
   } front_status_type;

endpackage

/* src/acsplit_front.sv */
// ============================================================================
// acsplit_front
// Classifies each input word against the zero run and the unit count and
// turns it into at most one command for the back end.
// ============================================================================
module acsplit_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic [acsplit_pkg::BYTE_W-1:0]      in_byte,
   input  logic                                stream_end,
   input  logic [acsplit_pkg::CSR_DATA_W-1:0]  max_units,
   output logic                                cmd_push,
   output acsplit_pkg::cmd_type                cmd,
   output acsplit_pkg::front_status_type       status
);

   logic [acsplit_pkg::ZRUN_W-1:0]   zero_run_ff;
   logic [acsplit_pkg::ZRUN_W-1:0]   zero_run_in;
   logic [acsplit_pkg::INDEX_W-1:0]  units_done_ff;
   logic [acsplit_pkg::INDEX_W-1:0]  units_done_in;
   logic [acsplit_pkg::RELCNT_W-1:0] held_cnt;
   logic [acsplit_pkg::INDEX_W-1:0]  units_next;
   logic                             make_cmd;

   // Held zeros that a release lets out; a long run holds none.
   assign held_cnt = (zero_run_ff <= acsplit_pkg::ZRUN_HELD_MAX)
                     ? zero_run_ff[acsplit_pkg::RELCNT_W-1:0] : '0;

   assign units_next = (units_done_ff == acsplit_pkg::INDEX_MAX)
                       ? units_done_ff : units_done_ff + 1'b1;

   // Classification of one accepted word.
   always_comb begin
      zero_run_in    = zero_run_ff;
      units_done_in  = units_done_ff;
      make_cmd       = 1'b0;
      cmd.rel_cnt    = '0;
      cmd.is_record  = 1'b0;
      cmd.data_byte  = in_byte;
      cmd.first_unit = (units_done_ff == '0);
      cmd.unit_index = units_done_ff;
      if (accept) begin
         if (stream_end) begin
            // Flush held zeros, close the last unit and start over.
            make_cmd      = 1'b1;
            cmd.rel_cnt   = held_cnt;
            cmd.is_record = 1'b1;
            zero_run_in   = '0;
            units_done_in = '0;
         end else if (units_done_ff < max_units) begin
            if (in_byte == acsplit_pkg::BYTE_ZERO) begin
               if (zero_run_ff < acsplit_pkg::ZRUN_HELD_MAX) begin
                  zero_run_in = zero_run_ff + 1'b1;
               end else begin
                  // Fourth zero or later: release everything as data.
                  make_cmd    = 1'b1;
                  cmd.rel_cnt = held_cnt;
                  zero_run_in = acsplit_pkg::ZRUN_RELEASED;
               end
            end else if ((in_byte == acsplit_pkg::BYTE_ONE) &&
                         (zero_run_ff == acsplit_pkg::ZRUN_HELD_MAX)) begin
               // Start code: close the current unit.
               make_cmd       = 1'b1;
               cmd.is_record  = 1'b1;
               cmd.unit_index = units_next;
               units_done_in  = units_next;
               zero_run_in    = '0;
            end else begin
               make_cmd    = 1'b1;
               cmd.rel_cnt = held_cnt;
               zero_run_in = '0;
            end
         end
      end
   end

   assign cmd_push = make_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_run_ff   <= '0;
         units_done_ff <= '0;
      end else begin
         zero_run_ff   <= zero_run_in;
         units_done_ff <= units_done_in;
      end
   end

   assign status.zero_run   = zero_run_ff;
   assign status.units_done = units_done_ff;

endmodule

/* src/acsplit_cmd_fifo.sv */
// ============================================================================
// acsplit_cmd_fifo
// Short command queue that decouples the classifier from the expander.
// ============================================================================
module acsplit_cmd_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  acsplit_pkg::cmd_type push_cmd,
   input  logic                 pop,
   output acsplit_pkg::cmd_type head_cmd,
   output logic                 head_valid,
   output logic                 full
);

   acsplit_pkg::cmd_type             cmd_mem_ff [acsplit_pkg::QUEUE_DEPTH];
   logic [acsplit_pkg::QPTR_W-1:0]   wr_ptr_ff;
   logic [acsplit_pkg::QPTR_W-1:0]   wr_ptr_in;
   logic [acsplit_pkg::QPTR_W-1:0]   rd_ptr_ff;
   logic [acsplit_pkg::QPTR_W-1:0]   rd_ptr_in;
   logic [acsplit_pkg::QCNT_W-1:0]   count_ff;
   logic [acsplit_pkg::QCNT_W-1:0]   count_in;
   logic                             do_push;
   logic                             do_pop;

   assign full       = (count_ff == acsplit_pkg::QCNT_W'(acsplit_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = cmd_mem_ff[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && head_valid;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         cmd_mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* src/acsplit_back.sv */
// ============================================================================
// acsplit_back
// Expands each command into result words, one per cycle while the result
// side pops them, and keeps the length and type of the unit being built.
// ============================================================================
module acsplit_back (
   input  logic                                clock,
   input  logic                                reset,
   input  acsplit_pkg::cmd_type                head_cmd,
   input  logic                                head_valid,
   output logic                                head_pop,
   input  logic                                insert_delimiter,
   input  logic                                rsp_pop,
   output logic                                rsp_valid,
   output logic                                rsp_kind,
   output logic [acsplit_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic [acsplit_pkg::LEN_W-1:0]       rsp_unit_length,
   output logic [acsplit_pkg::TYPE_W-1:0]      rsp_unit_type,
   output logic [acsplit_pkg::INDEX_W-1:0]     rsp_unit_index,
   output logic                                rsp_delimiter_before,
   output logic                                rsp_last
);

   logic [acsplit_pkg::RELCNT_W-1:0] step_ff;
   logic [acsplit_pkg::RELCNT_W-1:0] step_in;
   logic [acsplit_pkg::LEN_W-1:0]    length_ff;
   logic [acsplit_pkg::LEN_W-1:0]    length_in;
   logic [acsplit_pkg::TYPE_W-1:0]   first_type_ff;
   logic [acsplit_pkg::TYPE_W-1:0]   first_type_in;
   logic                             valid_ff;
   logic                             valid_in;
   logic                             kind_ff;
   logic [acsplit_pkg::BYTE_W-1:0]   byte_ff;
   logic [acsplit_pkg::LEN_W-1:0]    ulen_ff;
   logic [acsplit_pkg::TYPE_W-1:0]   utype_ff;
   logic [acsplit_pkg::INDEX_W-1:0]  uindex_ff;
   logic                             delim_ff;
   logic                             last_ff;

   logic                             slot_free;
   logic                             emit;
   logic                             is_release;
   logic                             is_data;
   logic [acsplit_pkg::BYTE_W-1:0]   data_val;
   logic [acsplit_pkg::TYPE_W-1:0]   data_type;
   logic                             unit_empty;

   assign slot_free  = !valid_ff || rsp_pop;
   assign emit       = head_valid && slot_free;
   assign is_release = (step_ff < head_cmd.rel_cnt);
   assign is_data    = is_release || !head_cmd.is_record;
   assign data_val   = is_release ? acsplit_pkg::BYTE_ZERO : head_cmd.data_byte;
   assign data_type  = data_val[acsplit_pkg::TYPE_W-1:0];
   assign unit_empty = (length_ff == '0);
   assign head_pop   = emit && !is_release;

   // Step through the held zeros, then the tail of the command.
   always_comb begin
      step_in       = step_ff;
      length_in     = length_ff;
      first_type_in = first_type_ff;
      if (emit) begin
         step_in = is_release ? step_ff + 1'b1 : '0;
         if (is_data) begin
            if (unit_empty) begin
               first_type_in = data_type;
            end
            if (length_ff != acsplit_pkg::LEN_MAX) begin
               length_in = length_ff + 1'b1;
            end
         end else begin
            length_in     = '0;
            first_type_in = '0;
         end
      end
   end

   // The output register holds a word until it is popped.
   assign valid_in = emit ? 1'b1 : (rsp_pop ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= '0;
         length_ff     <= '0;
         first_type_ff <= '0;
         valid_ff      <= 1'b0;
      end else begin
         step_ff       <= step_in;
         length_ff     <= length_in;
         first_type_ff <= first_type_in;
         valid_ff      <= valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (emit) begin
         last_ff <= !is_release;
         if (is_data) begin
            kind_ff   <= acsplit_pkg::KIND_DATA;
            byte_ff   <= data_val;
            ulen_ff   <= '0;
            utype_ff  <= '0;
            uindex_ff <= '0;
            delim_ff  <= unit_empty && head_cmd.first_unit && insert_delimiter &&
                         (data_type != acsplit_pkg::AUD_TYPE);
         end else begin
            kind_ff   <= acsplit_pkg::KIND_RECORD;
            byte_ff   <= '0;
            ulen_ff   <= length_ff;
            utype_ff  <= unit_empty ? '0 : first_type_ff;
            uindex_ff <= head_cmd.unit_index;
            delim_ff  <= 1'b0;
         end
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_kind             = kind_ff;
   assign rsp_out_byte         = byte_ff;
   assign rsp_unit_length      = ulen_ff;
   assign rsp_unit_type        = utype_ff;
   assign rsp_unit_index       = uindex_ff;
   assign rsp_delimiter_before = delim_ff;
   assign rsp_last             = last_ff;

endmodule

/* src/annexb_start_code_splitter_top.sv */
// An input word's first result passes the command queue, then the expander's
// output register. Throughput: one input word per cycle while each gives at
// most one result, the command queue has room and the result side pops; a word
// that releases held zeros gives up to four results, one per cycle while popped,
// set by the single output register of the expander (four-entry command queue).
// Reset: synchronous active high; clears control state, sets max_units to all ones.
// ============================================================================
// annexb_start_code_splitter_top
// Splits an Annex B byte stream into units at four-byte start codes.
// ============================================================================
`include "annexb_start_code_splitter_top_macros.svh"

module annexb_start_code_splitter_top (
   input  logic                                clock,
   input  logic                                reset,
   // Input queue side
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [acsplit_pkg::BYTE_W-1:0]      req_in_byte,
   input  logic                                req_stream_end,
   // Result queue side
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic                                rsp_kind,
   output logic [acsplit_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic [acsplit_pkg::LEN_W-1:0]       rsp_unit_length,
   output logic [acsplit_pkg::TYPE_W-1:0]      rsp_unit_type,
   output logic [acsplit_pkg::INDEX_W-1:0]     rsp_unit_index,
   output logic                                rsp_delimiter_before,
   output logic                                rsp_last,
   // Configuration
   input  logic                                csr_we,
   input  logic [acsplit_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [acsplit_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic [acsplit_pkg::CSR_DATA_W-1:0] max_units_ff;
   logic [acsplit_pkg::CSR_DATA_W-1:0] max_units_in;
   logic                               insert_delim_ff;
   logic                               insert_delim_in;

   logic                               accept;
   logic                               cmd_push;
   acsplit_pkg::cmd_type               push_cmd;
   acsplit_pkg::cmd_type               head_cmd;
   logic                               head_valid;
   logic                               head_pop;
   logic                               fifo_full;
   logic                               rsp_valid;
   acsplit_pkg::front_status_type      front_status;

   // Configuration registers.
   always_comb begin
      max_units_in    = max_units_ff;
      insert_delim_in = insert_delim_ff;
      if (csr_we) begin
         case (csr_index)
            acsplit_pkg::CSR_MAX_UNITS:    max_units_in    = csr_wdata;
            acsplit_pkg::CSR_INSERT_DELIM: insert_delim_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_units_ff    <= '1;
         insert_delim_ff <= 1'b0;
      end else begin
         max_units_ff    <= max_units_in;
         insert_delim_ff <= insert_delim_in;
      end
   end

   // A word is taken whenever the command queue has room.
   assign req_full = fifo_full;
   assign accept   = req_push && !fifo_full;

   acsplit_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .in_byte    (req_in_byte),
      .stream_end (req_stream_end),
      .max_units  (max_units_ff),
      .cmd_push   (cmd_push),
      .cmd        (push_cmd),
      .status     (front_status)
   );

   acsplit_cmd_fifo u_cmd_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_cmd   (push_cmd),
      .pop        (head_pop),
      .head_cmd   (head_cmd),
      .head_valid (head_valid),
      .full       (fifo_full)
   );

   acsplit_back u_back (
      .clock                (clock),
      .reset                (reset),
      .head_cmd             (head_cmd),
      .head_valid           (head_valid),
      .head_pop             (head_pop),
      .insert_delimiter     (insert_delim_ff),
      .rsp_pop              (rsp_pop),
      .rsp_valid            (rsp_valid),
      .rsp_kind             (rsp_kind),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_unit_length      (rsp_unit_length),
      .rsp_unit_type        (rsp_unit_type),
      .rsp_unit_index       (rsp_unit_index),
      .rsp_delimiter_before (rsp_delimiter_before),
      .rsp_last             (rsp_last)
   );

   assign rsp_empty = !rsp_valid;

   // A record always closes the results of its input word.
   `ACS_ASSERT_IMPL(a_record_is_last, clock, reset, !rsp_empty && rsp_kind, rsp_last)
   // The delimiter flag only rides on data words.
   `ACS_ASSERT_IMPL(a_delim_on_data, clock, reset, !rsp_empty && rsp_delimiter_before, !rsp_kind)
   // The classifier never produces a command the queue cannot take.
   `ACS_ASSERT_IMPL(a_no_cmd_overflow, clock, reset, cmd_push, !fifo_full)
   // Stream end returns the classifier to its reset state.
   `ACS_ASSERT_NEXT(a_end_clears, clock, reset, accept && req_stream_end, front_status == '0)

endmodule

/* verif/tb_annexb_start_code_splitter_top.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_annexb_start_code_splitter_top
// Feeds byte streams into the start code splitter through its input queue,
// drains result words with random stalls and compares every word, field by
// field, with the output of a splitter model kept inside this bench.
// ============================================================================
module tb_annexb_start_code_splitter_top;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAX_WAIT     = 18;
   localparam int DRAIN_CYCLES = 8;
   localparam int PRINT_LIMIT  = 40;

   // One result word as the splitter presents it.
   typedef struct packed {
      logic                            kind;
      logic [acsplit_pkg::BYTE_W-1:0]  out_byte;
      logic [acsplit_pkg::LEN_W-1:0]   unit_length;
      logic [acsplit_pkg::TYPE_W-1:0]  unit_type;
      logic [acsplit_pkg::INDEX_W-1:0] unit_index;
      logic                            delimiter_before;
      logic                            last;
   } split_word_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_push;
   logic                               req_full;
   logic [acsplit_pkg::BYTE_W-1:0]     req_in_byte;
   logic                               req_stream_end;
   logic                               rsp_empty;
   logic                               rsp_pop;
   logic                               rsp_kind;
   logic [acsplit_pkg::BYTE_W-1:0]     rsp_out_byte;
   logic [acsplit_pkg::LEN_W-1:0]      rsp_unit_length;
   logic [acsplit_pkg::TYPE_W-1:0]     rsp_unit_type;
   logic [acsplit_pkg::INDEX_W-1:0]    rsp_unit_index;
   logic                               rsp_delimiter_before;
   logic                               rsp_last;
   logic                               csr_we;
   logic [acsplit_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [acsplit_pkg::CSR_DATA_W-1:0] csr_wdata;

   annexb_start_code_splitter_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_in_byte          (req_in_byte),
      .req_stream_end       (req_stream_end),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_kind             (rsp_kind),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_unit_length      (rsp_unit_length),
      .rsp_unit_type        (rsp_unit_type),
      .rsp_unit_index       (rsp_unit_index),
      .rsp_delimiter_before (rsp_delimiter_before),
      .rsp_last             (rsp_last),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Words still owed by the splitter, oldest first, and the words of the
   // stream byte being modeled right now.
   split_word_type words_due[$];
   split_word_type byte_words[$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int words_sent     = 0;
   bit feed_steady    = 1'b0;
   bit drain_steady   = 1'b0;

   // Splitter model state, at its reset values.
   logic [acsplit_pkg::ZRUN_W-1:0]  held_zeros   = '0;
   logic [acsplit_pkg::LEN_W-1:0]   unit_bytes   = '0;
   logic [acsplit_pkg::TYPE_W-1:0]  unit_first   = '0;
   logic [acsplit_pkg::INDEX_W-1:0] units_ended  = '0;
   logic [acsplit_pkg::LEN_W-1:0]   unit_limit   = '1;
   logic                            aud_wanted   = 1'b0;

   // A data word of the current unit; the unit's first byte fixes its type.
   function automatic void emit_data(input logic [acsplit_pkg::BYTE_W-1:0] value);
      split_word_type w;
      w = '0;
      w.kind = acsplit_pkg::KIND_DATA;
      w.out_byte = value;
      if (unit_bytes == '0) begin
         unit_first = value[acsplit_pkg::TYPE_W-1:0];
         if (units_ended == '0 && aud_wanted && unit_first != acsplit_pkg::AUD_TYPE)
            w.delimiter_before = 1'b1;
      end
      if (unit_bytes != acsplit_pkg::LEN_MAX)
         unit_bytes = unit_bytes + 1'b1;
      byte_words.push_back(w);
   endfunction

   // Held zeros come out as data; a released long run holds none.
   function automatic void release_zeros();
      int n;
      n = (held_zeros <= acsplit_pkg::ZRUN_HELD_MAX) ? int'(held_zeros) : 0;
      for (int i = 0; i < n; i++)
         emit_data(acsplit_pkg::BYTE_ZERO);
   endfunction

   function automatic void emit_record();
      split_word_type w;
      w = '0;
      w.kind = acsplit_pkg::KIND_RECORD;
      w.unit_length = unit_bytes;
      w.unit_type = (unit_bytes != '0) ? unit_first : '0;
      w.unit_index = units_ended;
      byte_words.push_back(w);
   endfunction

   // Splits one accepted stream byte and queues the words it causes.
   function automatic void split_stream_byte(input logic [acsplit_pkg::BYTE_W-1:0] value,
                                             input logic stream_end);
      split_word_type w;
      byte_words.delete();
      if (stream_end) begin
         release_zeros();
         emit_record();
         held_zeros = '0;
         unit_bytes = '0;
         unit_first = '0;
         units_ended = '0;
      end else if (units_ended < unit_limit) begin
         if (value == acsplit_pkg::BYTE_ZERO) begin
            if (held_zeros < acsplit_pkg::ZRUN_HELD_MAX) begin
               held_zeros = held_zeros + 1'b1;
            end else begin
               if (held_zeros == acsplit_pkg::ZRUN_HELD_MAX)
                  release_zeros();
               emit_data(acsplit_pkg::BYTE_ZERO);
               held_zeros = acsplit_pkg::ZRUN_RELEASED;
            end
         end else if (value == acsplit_pkg::BYTE_ONE &&
                      held_zeros == acsplit_pkg::ZRUN_HELD_MAX) begin
            if (units_ended != acsplit_pkg::INDEX_MAX)
               units_ended = units_ended + 1'b1;
            emit_record();
            held_zeros = '0;
            unit_bytes = '0;
            unit_first = '0;
         end else begin
            release_zeros();
            emit_data(value);
            held_zeros = '0;
         end
      end
      if (byte_words.size() > 0) begin
         w = byte_words.pop_back();
         w.last = 1'b1;
         byte_words.push_back(w);
      end
      foreach (byte_words[i])
         words_due.push_back(byte_words[i]);
   endfunction

   // Wait before the next handshake: often none, sometimes long.
   function automatic int draw_wait(input bit steady);
      if (steady)
         return 0;
      case ($urandom_range(0, 3))
         0, 1:    return 0;
         2:       return $urandom_range(1, 3);
         default: return $urandom_range(0, MAX_WAIT);
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("cycle %0d: %s is %0h, expected %0h", cycle_count, what, got, want);
   endtask

   // Sends one word into the input queue; called and left at a falling edge.
   task automatic send_word(input logic [acsplit_pkg::BYTE_W-1:0] value,
                            input logic stream_end);
      int gap;
      gap = draw_wait(feed_steady);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_in_byte <= value;
      req_stream_end <= stream_end;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      words_sent++;
      split_stream_byte(value, stream_end);
      if ($urandom_range(0, 31) == 0)
         feed_steady = !feed_steady;
      @(negedge clock);
   endtask

   task automatic send_zeros(input int count);
      repeat (count) send_word(acsplit_pkg::BYTE_ZERO, 1'b0);
   endtask

   task automatic send_start_code();
      send_zeros(3);
      send_word(acsplit_pkg::BYTE_ONE, 1'b0);
   endtask

   // Lets the splitter run dry before a register write or the end of the run.
   task automatic wait_idle();
      req_push <= 1'b0;
      while (words_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Writes both registers on back-to-back cycles; the flag register gets
   // random upper bits, which it must ignore.
   task automatic write_config(input logic [acsplit_pkg::LEN_W-1:0] limit,
                               input logic aud);
      logic [acsplit_pkg::CSR_DATA_W-1:0] flag_data;
      flag_data = $urandom;
      flag_data[0] = aud;
      csr_we <= 1'b1;
      csr_index <= acsplit_pkg::CSR_MAX_UNITS;
      csr_wdata <= limit;
      @(negedge clock);
      csr_index <= acsplit_pkg::CSR_INSERT_DELIM;
      csr_wdata <= flag_data;
      @(negedge clock);
      csr_we <= 1'b0;
      unit_limit = limit;
      aud_wanted = flag_data[0];
   endtask

   function automatic logic [acsplit_pkg::BYTE_W-1:0] draw_payload_byte();
      logic [31:0]                    raw;
      logic [acsplit_pkg::BYTE_W-1:0] value;
      raw = $urandom;
      value = raw[acsplit_pkg::BYTE_W-1:0];
      case ($urandom_range(0, 9))
         0, 1, 2: value = acsplit_pkg::BYTE_ZERO;
         3:       value = acsplit_pkg::BYTE_ONE;
         4:       value[acsplit_pkg::TYPE_W-1:0] = acsplit_pkg::AUD_TYPE;
         default: ;
      endcase
      return value;
   endfunction

   // Zero runs, most of which must not end a unit, and stray bytes.
   task automatic send_noise();
      case ($urandom_range(0, 3))
         0: begin
            send_zeros(2);
            send_word(acsplit_pkg::BYTE_ONE, 1'b0);
         end
         1: begin
            send_zeros($urandom_range(4, 6));
            send_word(acsplit_pkg::BYTE_ONE, 1'b0);
         end
         2: begin
            send_zeros(3);
            send_word(draw_payload_byte(), 1'b0);
         end
         default: begin
            repeat ($urandom_range(1, 3)) send_word(draw_payload_byte(), 1'b0);
         end
      endcase
   endtask

   // Units of random content cut by start codes, with noise and early ends.
   task automatic run_stream_phase(input logic [acsplit_pkg::LEN_W-1:0] limit,
                                   input logic aud, input int quota);
      int payload;
      wait_idle();
      write_config(limit, aud);
      words_sent = 0;
      while (words_sent < quota) begin
         case ($urandom_range(0, 11))
            0:    send_word(draw_payload_byte(), 1'b1);
            1, 2: send_noise();
            default: begin
               payload = ($urandom_range(0, 15) == 0) ? $urandom_range(12, 20)
                                                     : $urandom_range(0, 5);
               repeat (payload) send_word(draw_payload_byte(), 1'b0);
               send_start_code();
            end
         endcase
      end
      send_word(draw_payload_byte(), 1'b1);
   endtask

   // Data, start codes, a long zero run, held zeros released by data and by
   // the stream end, with the delimiter flag on.
   task automatic test_unit_split();
      wait_idle();
      write_config('1, 1'b1);
      send_word(8'hE5, 1'b0);
      send_start_code();
      send_word(8'h49, 1'b0);
      send_zeros(4);
      send_word(acsplit_pkg::BYTE_ONE, 1'b0);
      send_zeros(2);
      send_word(8'h80, 1'b0);
      send_zeros(3);
      send_word(8'hFF, 1'b1);
   endtask

   // No delimiter for a first unit of type 9; an empty stream; a first unit
   // that opens with held zeros.
   task automatic test_delimiter_rules();
      send_word(8'h29, 1'b0);
      send_word(acsplit_pkg::BYTE_ZERO, 1'b1);
      send_word(8'h5A, 1'b1);
      send_zeros(2);
      send_word(8'h41, 1'b0);
      send_word(acsplit_pkg::BYTE_ONE, 1'b1);
   endtask

   // After the unit limit, bytes and zeros are dropped and none are held, and the
   // stream end still gives a record.
   task automatic test_unit_limit();
      wait_idle();
      write_config(1, 1'b0);
      send_word(8'h21, 1'b0);
      send_start_code();
      send_word(8'h33, 1'b0);
      send_zeros(2);
      send_word(8'h7F, 1'b1);
   endtask

   task automatic test_random_streams();
      run_stream_phase('1, 1'b1, 40);
      run_stream_phase($urandom_range(2, 4), 1'($urandom_range(0, 1)), 30);
      run_stream_phase(0, 1'b1, 12);
      run_stream_phase(1, 1'b1, 20);
      run_stream_phase($urandom, 1'($urandom_range(0, 1)), 40);
      run_stream_phase('1, 1'b0, 25);
   endtask

   // Result side: pops with random stalls, some stretches without any.
   initial begin : result_drain
      int stall;
      rsp_pop = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = draw_wait(drain_steady);
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty)
            @(posedge clock);
         if ($urandom_range(0, 31) == 0)
            drain_steady = !drain_steady;
         @(negedge clock);
      end
   end

   // Every popped word is compared with the oldest word still due.
   always @(posedge clock) begin : result_check
      split_word_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (words_due.size() == 0) begin
            report_mismatch("word with none due, kind", 32'(rsp_kind), '0);
         end else begin
            want = words_due.pop_front();
            if (rsp_kind !== want.kind)
               report_mismatch("kind", 32'(rsp_kind), 32'(want.kind));
            if (rsp_out_byte !== want.out_byte)
               report_mismatch("out_byte", 32'(rsp_out_byte), 32'(want.out_byte));
            if (rsp_unit_length !== want.unit_length)
               report_mismatch("unit_length", rsp_unit_length, want.unit_length);
            if (rsp_unit_type !== want.unit_type)
               report_mismatch("unit_type", 32'(rsp_unit_type), 32'(want.unit_type));
            if (rsp_unit_index !== want.unit_index)
               report_mismatch("unit_index", rsp_unit_index, want.unit_index);
            if (rsp_delimiter_before !== want.delimiter_before)
               report_mismatch("delimiter_before", 32'(rsp_delimiter_before),
                               32'(want.delimiter_before));
            if (rsp_last !== want.last)
               report_mismatch("last", 32'(rsp_last), 32'(want.last));
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout with %0d words due", words_due.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      req_push = 1'b0;
      req_in_byte = '0;
      req_stream_end = 1'b0;
      csr_we = 1'b0;
      csr_index = acsplit_pkg::CSR_MAX_UNITS;
      csr_wdata = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_unit_split();
      test_delimiter_rules();
      test_unit_limit();
      test_random_streams();
      wait_idle();
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
